// ===== design/fxa_pkg.sv =====
// ----------------------------------------------------------------------------
// fxa_pkg: shared types for the Q24.8 fixed-point ALU
// Action codes and the control word that travels down the divider cells.
// ----------------------------------------------------------------------------
package fxa_pkg;

  localparam int unsigned ActW = 4;

  typedef enum logic [ActW-1:0] {
    ACT_ADD      = 4'd0,
    ACT_SUB      = 4'd1,
    ACT_MUL      = 4'd2,
    ACT_DIV      = 4'd3,
    ACT_LT       = 4'd4,
    ACT_GT       = 4'd5,
    ACT_LE       = 4'd6,
    ACT_GE       = 4'd7,
    ACT_EQ       = 4'd8,
    ACT_NE       = 4'd9,
    ACT_MIN      = 4'd10,
    ACT_MAX      = 4'd11,
    ACT_INC      = 4'd12,
    ACT_DEC      = 4'd13,
    ACT_FROM_INT = 4'd14,
    ACT_TO_INT   = 4'd15
  } act_e;

  // Control word that accompanies each transaction through the cell chain
  typedef struct packed {
    logic valid;
    logic is_div;
    logic neg;
    logic flag;
    logic status;
  } ctrl_t;

endpackage

// ===== design/fxa_front.sv =====
// ----------------------------------------------------------------------------
// fxa_front: operand decode, simple operations and multiplier
// Three register stages: decode and magnitudes, product, sign fix-up. Loads
// the divider chain with the widened dividend or the finished result.
// ----------------------------------------------------------------------------
module fxa_front
  import fxa_pkg::*;
#(
  parameter int unsigned DW = 32,
  parameter int unsigned F  = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [ActW-1:0]      action_i,
  input  logic signed [DW-1:0] operand_a_i,
  input  logic signed [DW-1:0] operand_b_i,
  output ctrl_t                ctrl_o,
  output logic [DW-1:0]        rem_o,
  output logic [DW+F-1:0]      nq_o,
  output logic [DW-1:0]        dsr_o
);

  act_e          act;
  logic          a_lt_b, b_lt_a, a_eq_b;
  logic [DW-1:0] res, mag_a, mag_b;
  logic          flg, neg;

  logic          s1_valid_q;
  act_e          s1_act_q;
  logic [DW-1:0] s1_ma_q, s1_mb_q, s1_res_q;
  logic          s1_neg_q, s1_flag_q, s1_bz_q;

  logic [2*DW-1:0] prod;
  logic [DW-1:0]   val_d;

  logic          s2_valid_q;
  act_e          s2_act_q;
  logic [DW-1:0] s2_ma_q, s2_mb_q, s2_val_q;
  logic          s2_neg_q, s2_flag_q, s2_bz_q;

  logic          s2_is_div, s2_fix;
  logic [DW-1:0] fixed_val;
  ctrl_t         ctrl_d, ctrl_q;
  logic [DW+F-1:0] nq_d, nq_q;
  logic [DW-1:0]   dsr_q;

  // Stage 1: decode, compare, add and operand magnitudes
  always_comb begin
    act    = act_e'(action_i);
    a_lt_b = operand_a_i < operand_b_i;
    b_lt_a = operand_b_i < operand_a_i;
    a_eq_b = operand_a_i == operand_b_i;
    mag_a  = operand_a_i[DW-1] ? -operand_a_i : operand_a_i;
    mag_b  = operand_b_i[DW-1] ? -operand_b_i : operand_b_i;
    neg    = operand_a_i[DW-1] ^ operand_b_i[DW-1];
    res    = '0;
    flg    = 1'b0;
    unique case (act)
      ACT_ADD:      res = operand_a_i + operand_b_i;
      ACT_SUB:      res = operand_a_i - operand_b_i;
      ACT_MUL:      res = '0;
      ACT_DIV:      res = '0;
      ACT_LT:       flg = a_lt_b;
      ACT_GT:       flg = b_lt_a;
      ACT_LE:       flg = !b_lt_a;
      ACT_GE:       flg = !a_lt_b;
      ACT_EQ:       flg = a_eq_b;
      ACT_NE:       flg = !a_eq_b;
      ACT_MIN:      res = b_lt_a ? operand_b_i : operand_a_i;
      ACT_MAX:      res = a_lt_b ? operand_b_i : operand_a_i;
      ACT_INC:      res = operand_a_i + DW'(1);
      ACT_DEC:      res = operand_a_i - DW'(1);
      ACT_FROM_INT: res = operand_a_i << F;
      ACT_TO_INT: begin
        res = '0;
        neg = operand_a_i[DW-1];
      end
      default:      res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      ctrl_q     <= '0;
    end else begin
      s1_valid_q <= take_i;
      s2_valid_q <= s1_valid_q;
      ctrl_q     <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_act_q  <= act;
    s1_ma_q   <= mag_a;
    s1_mb_q   <= mag_b;
    s1_res_q  <= res;
    s1_neg_q  <= neg;
    s1_flag_q <= flg;
    s1_bz_q   <= (operand_b_i == '0);
  end

  // Stage 2: unsigned product and rounded integer part
  assign prod = s1_ma_q * s1_mb_q;

  always_comb begin
    priority if (s1_act_q == ACT_MUL) begin
      val_d = prod[DW+F-1:F];
    end else if (s1_act_q == ACT_TO_INT) begin
      val_d = (s1_ma_q >> F) + DW'(s1_ma_q[F-1]);
    end else begin
      val_d = s1_res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_act_q  <= s1_act_q;
    s2_ma_q   <= s1_ma_q;
    s2_mb_q   <= s1_mb_q;
    s2_val_q  <= val_d;
    s2_neg_q  <= s1_neg_q;
    s2_flag_q <= s1_flag_q;
    s2_bz_q   <= s1_bz_q;
  end

  // Stage 3: apply sign, load the chain
  always_comb begin
    s2_is_div = (s2_act_q == ACT_DIV);
    s2_fix    = (s2_act_q == ACT_MUL) || (s2_act_q == ACT_TO_INT);
    fixed_val = (s2_fix && s2_neg_q) ? -s2_val_q : s2_val_q;
    nq_d      = s2_is_div ? {s2_ma_q, {F{1'b0}}} : {{F{1'b0}}, fixed_val};
    ctrl_d.valid  = s2_valid_q;
    ctrl_d.is_div = s2_is_div;
    ctrl_d.neg    = s2_is_div & s2_neg_q;
    ctrl_d.flag   = s2_flag_q;
    ctrl_d.status = s2_is_div & s2_bz_q;
  end

  always_ff @(posedge clk_i) begin
    nq_q  <= nq_d;
    dsr_q <= s2_mb_q;
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = '0;
  assign nq_o   = nq_q;
  assign dsr_o  = dsr_q;

endmodule

// ===== design/fxa_div_cell.sv =====
// ----------------------------------------------------------------------------
// fxa_div_cell: one restoring-division step
// Shifts the next dividend bit into the remainder, subtracts the divisor when
// it fits and shifts the quotient bit in; passes other transactions unchanged.
// ----------------------------------------------------------------------------
module fxa_div_cell
  import fxa_pkg::*;
#(
  parameter int unsigned DW = 32,
  parameter int unsigned F  = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  input  logic [DW-1:0]    rem_i,
  input  logic [DW+F-1:0]  nq_i,
  input  logic [DW-1:0]    dsr_i,
  output ctrl_t            ctrl_o,
  output logic [DW-1:0]    rem_o,
  output logic [DW+F-1:0]  nq_o,
  output logic [DW-1:0]    dsr_o
);

  logic [DW:0]     shifted, diff;
  logic            fits;
  logic [DW-1:0]   rem_d, rem_q, dsr_q;
  logic [DW+F-1:0] nq_d, nq_q;
  ctrl_t           ctrl_q;

  always_comb begin
    shifted = {rem_i, nq_i[DW+F-1]};
    diff    = shifted - {1'b0, dsr_i};
    fits    = shifted >= {1'b0, dsr_i};
    if (ctrl_i.is_div) begin
      rem_d = fits ? diff[DW-1:0] : shifted[DW-1:0];
      nq_d  = {nq_i[DW+F-2:0], fits};
    end else begin
      // hold the finished result
      rem_d = rem_i;
      nq_d  = nq_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nq_q  <= nq_d;
    dsr_q <= dsr_i;
  end

  assign ctrl_o = ctrl_q;
  assign rem_o  = rem_q;
  assign nq_o   = nq_q;
  assign dsr_o  = dsr_q;

endmodule

// ===== design/fixed_point_q24_8_alu_core.sv =====
// Throughput: one transaction per cycle; busy stays low.
// Every transaction walks from accept to done_o through the divider chain,
// one cell per quotient bit of the widened dividend.
// Reset clears all valid bits; results are never stalled by the receiver.
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_core: signed Q24.8 fixed-point ALU
// Front end with decode and multiplier, a chain of restoring-division cells
// and a registered output stage with the final divide sign fix-up.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu_core
  import fxa_pkg::*;
#(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned DATA_WIDTH    = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [ActW-1:0]              action_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] result_o,
  output logic                         flag_o,
  output logic                         status_o
);

  localparam int unsigned DW  = DATA_WIDTH;
  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned NC  = DW + F;
  localparam int unsigned Lat = NC + 4;

  ctrl_t           ch_ctrl [NC+1];
  logic [DW-1:0]   ch_rem  [NC+1];
  logic [DW+F-1:0] ch_nq   [NC+1];
  logic [DW-1:0]   ch_dsr  [NC+1];

  logic            take;
  ctrl_t           last;
  logic [DW-1:0]   quo, result_d, result_q;
  logic            done_q, flag_q, status_q;

  assign busy = 1'b0;
  assign take = start & !busy;

  fxa_front #(
    .DW (DW),
    .F  (F)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .action_i    (action_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .ctrl_o      (ch_ctrl[0]),
    .rem_o       (ch_rem[0]),
    .nq_o        (ch_nq[0]),
    .dsr_o       (ch_dsr[0])
  );

  for (genvar i = 0; i < NC; i++) begin : g_cell
    fxa_div_cell #(
      .DW (DW),
      .F  (F)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ch_ctrl[i]),
      .rem_i  (ch_rem[i]),
      .nq_i   (ch_nq[i]),
      .dsr_i  (ch_dsr[i]),
      .ctrl_o (ch_ctrl[i+1]),
      .rem_o  (ch_rem[i+1]),
      .nq_o   (ch_nq[i+1]),
      .dsr_o  (ch_dsr[i+1])
    );
  end

  // Quotient keeps only its low word; drop it on divide by zero, else apply the divide sign
  always_comb begin
    last = ch_ctrl[NC];
    quo  = ch_nq[NC][DW-1:0];
    if (last.is_div) begin
      priority if (last.status) begin
        result_d = '0;
      end else if (last.neg) begin
        result_d = -quo;
      end else begin
        result_d = quo;
      end
    end else begin
      result_d = quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= last.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    flag_q   <= last.flag;
    status_q <= last.status;
  end

  assign done_o   = done_q;
  assign result_o = result_q;
  assign flag_o   = flag_q;
  assign status_o = status_q;

`ifndef SYNTH
  a_lat_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Lat done_o)
    else $error("transaction lost in pipeline");

  a_lat_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Lat))
    else $error("result without transaction");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (result_o == '0) && !flag_o)
    else $error("divide by zero result not cleared");

  a_div_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last.valid && (last.status || last.neg)) |-> last.is_div)
    else $error("divide control on non-divide transaction");
`endif

endmodule
